// File: rtl/core/mmh_pkg.sv
// shared constants, command and status types for the streaming murmur64 hash
package mmh_pkg;

  // mixing constant and its halves
  localparam logic [63:0] MixMul   = 64'hc6a4a7935bd1e995;
  localparam logic [31:0] MixMulLo = MixMul[31:0];
  localparam logic [31:0] MixMulHi = MixMul[63:32];
  localparam int unsigned MixShift = 47;

  localparam int unsigned LenWidth   = 31;
  localparam int unsigned WordWidth  = 64;
  localparam int unsigned CountWidth = 4;

  // multiplier operand select
  typedef enum logic [2:0] {
    OP_LEN,
    OP_K,
    OP_H_MIX,
    OP_FIN
  } op_sel_e;

  // write-back target after a multiply
  typedef enum logic [2:0] {
    WB_NONE,
    WB_SEED,
    WB_KEY1,
    WB_KEY2,
    WB_H,
    WB_FIN
  } wb_sel_e;

  // controller to datapath
  typedef struct packed {
    logic    load_in;
    logic    mul_issue;
    op_sel_e op_sel;
    wb_sel_e wb_sel;
    logic    load_out;
  } cmd_t;

  // datapath to controller: flags of the item in flight
  typedef struct packed {
    logic first;
    logic last;
    logic full;
    logic part;
  } status_t;

endpackage

// File: rtl/core/mmh_mul.sv
// two-stage 64-bit multiply by the mixing constant, low 64 bits of the product
module mmh_mul (
  input  logic                         clk_i,
  input  logic                         issue_i,
  input  logic [mmh_pkg::WordWidth-1:0] operand_i,
  output logic [mmh_pkg::WordWidth-1:0] product_o
);
  import mmh_pkg::*;

  logic [63:0] p0_d, p0_q;
  logic [31:0] p1_d, p1_q;
  logic [31:0] p2_d, p2_q;
  logic [31:0] hi_sum;

  // partial products, 32 x 32 each
  always_comb begin
    p0_d = operand_i[31:0] * MixMulLo;
    p1_d = operand_i[31:0] * MixMulHi;
    p2_d = operand_i[63:32] * MixMulLo;
  end

  // partial product registers, loaded on issue only
  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      p0_q <= p0_d;
      p1_q <= p1_d;
      p2_q <= p2_d;
    end
  end

  // final sum of the partial products
  assign hi_sum    = p1_q + p2_q;
  assign product_o = p0_q + {hi_sum, 32'h0000_0000};

endmodule

// File: rtl/core/mmh_datapath.sv
// hash datapath: seed, running hash, key word, shared multiplier and result register
module mmh_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mmh_pkg::WordWidth-1:0]   cfg_wdata_i,
  input  logic                            first_word_i,
  input  logic [mmh_pkg::LenWidth-1:0]    total_len_i,
  input  logic [mmh_pkg::WordWidth-1:0]   data_word_i,
  input  logic [mmh_pkg::CountWidth-1:0]  valid_bytes_i,
  input  logic                            last_word_i,
  input  mmh_pkg::cmd_t                   cmd_i,
  output mmh_pkg::status_t                status_o,
  output logic [mmh_pkg::WordWidth-1:0]   hash_value_o
);
  import mmh_pkg::*;

  logic [63:0]         seed_q;
  logic [63:0]         h_q;
  logic [63:0]         k_q;
  logic [LenWidth-1:0] len_q;
  status_t             status_q;
  logic [63:0]         hash_q;

  logic [63:0] masked_word;
  logic        in_full;
  logic        in_part;
  logic [63:0] mul_operand;
  logic [63:0] product;

  // byte masking of a partial word
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      masked_word[j*8 +: 8] = (CountWidth'(j) < valid_bytes_i) ? data_word_i[j*8 +: 8] : 8'h00;
    end
  end

  // eight or more valid bytes take the body mix
  assign in_full = valid_bytes_i[3];
  assign in_part = !in_full && (valid_bytes_i != '0);

  // operand select for the shared multiplier
  always_comb begin
    case (cmd_i.op_sel)
      OP_LEN:   mul_operand = {{(64 - LenWidth){1'b0}}, len_q};
      OP_K:     mul_operand = k_q;
      OP_H_MIX: mul_operand = h_q ^ k_q;
      OP_FIN:   mul_operand = h_q ^ (h_q >> MixShift);
      default:  mul_operand = k_q;
    endcase
  end

  mmh_mul u_mul (
    .clk_i     (clk_i),
    .issue_i   (cmd_i.mul_issue),
    .operand_i (mul_operand),
    .product_o (product)
  );

  // seed register, running hash and item flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= '0;
      h_q      <= '0;
      status_q <= '0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      if (cmd_i.load_in) begin
        status_q.first <= first_word_i;
        status_q.last  <= last_word_i;
        status_q.full  <= in_full;
        status_q.part  <= in_part;
      end
      case (cmd_i.wb_sel)
        WB_SEED: h_q <= seed_q ^ product;
        WB_H:    h_q <= product;
        WB_FIN:  h_q <= product ^ (product >> MixShift);
        default: h_q <= h_q;
      endcase
    end
  end

  // key word, length and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      len_q <= total_len_i;
      k_q   <= in_full ? data_word_i : masked_word;
    end else begin
      case (cmd_i.wb_sel)
        WB_KEY1: k_q <= product ^ (product >> MixShift);
        WB_KEY2: k_q <= product;
        default: k_q <= k_q;
      endcase
    end
    if (cmd_i.load_out) begin
      hash_q <= h_q;
    end
  end

  assign status_o     = status_q;
  assign hash_value_o = hash_q;

endmodule

// File: rtl/core/mmh_ctrl.sv
// controller: sequences seeding, body or tail mix, finaliser and result hand-off
module mmh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  mmh_pkg::status_t  status_i,
  output mmh_pkg::cmd_t     cmd_o
);
  import mmh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_SEED_MUL,
    S_SEED_WB,
    S_KEY_MUL1,
    S_KEY_WB1,
    S_KEY_MUL2,
    S_KEY_WB2,
    S_H_MUL,
    S_H_WB,
    S_FIN_MUL,
    S_FIN_WB,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q;
  logic   out_valid_q, out_valid_d;
  state_e body_st, tail_st;
  logic   slot_free;

  // routing after seeding and after the word mix
  always_comb begin
    tail_st = status_i.last ? S_FIN_MUL : S_IDLE;
    if (status_i.full) begin
      body_st = S_KEY_MUL1;
    end else if (status_i.part) begin
      body_st = S_H_MUL;
    end else begin
      body_st = tail_st;
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.op_sel  = OP_K;
    cmd_o.wb_sel  = WB_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_q) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_START;
        end
      end
      S_START:    state_d = status_i.first ? S_SEED_MUL : body_st;
      S_SEED_MUL: begin
        cmd_o.mul_issue = 1'b1;
        cmd_o.op_sel    = OP_LEN;
        state_d         = S_SEED_WB;
      end
      S_SEED_WB: begin
        cmd_o.wb_sel = WB_SEED;
        state_d      = body_st;
      end
      S_KEY_MUL1: begin
        cmd_o.mul_issue = 1'b1;
        cmd_o.op_sel    = OP_K;
        state_d         = S_KEY_WB1;
      end
      S_KEY_WB1: begin
        cmd_o.wb_sel = WB_KEY1;
        state_d      = S_KEY_MUL2;
      end
      S_KEY_MUL2: begin
        cmd_o.mul_issue = 1'b1;
        cmd_o.op_sel    = OP_K;
        state_d         = S_KEY_WB2;
      end
      S_KEY_WB2: begin
        cmd_o.wb_sel = WB_KEY2;
        state_d      = S_H_MUL;
      end
      S_H_MUL: begin
        cmd_o.mul_issue = 1'b1;
        cmd_o.op_sel    = OP_H_MIX;
        state_d         = S_H_WB;
      end
      S_H_WB: begin
        cmd_o.wb_sel = WB_H;
        state_d      = tail_st;
      end
      S_FIN_MUL: begin
        cmd_o.mul_issue = 1'b1;
        cmd_o.op_sel    = OP_FIN;
        state_d         = S_FIN_WB;
      end
      S_FIN_WB: begin
        cmd_o.wb_sel = WB_FIN;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // state and registered handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_ready_q  <= (state_d == S_IDLE);
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/murmur64_stream_hash.sv
// streaming 64-bit murmur hash: one key word per item, hash out on the last word
// items are taken one at a time, paced by the one shared two-stage multiplier: the next
//   item is not taken until the last is through; three multiplies for a full word, one each
//   for a tail word, seeding and the finaliser, plus accept and dispatch, and hand-off on a last word
// the hash of a last word is held back while an earlier result waits to be taken
// reset: asynchronous, active low; seed and running hash clear to zero, no result pending
module murmur64_stream_hash (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mmh_pkg::WordWidth-1:0]   cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            first_word_i,
  input  logic [mmh_pkg::LenWidth-1:0]    total_len_i,
  input  logic [mmh_pkg::WordWidth-1:0]   data_word_i,
  input  logic [mmh_pkg::CountWidth-1:0]  valid_bytes_i,
  input  logic                            last_word_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mmh_pkg::WordWidth-1:0]   hash_value_o
);
  import mmh_pkg::*;

  cmd_t    cmd;
  status_t status;

  mmh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mmh_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .first_word_i  (first_word_i),
    .total_len_i   (total_len_i),
    .data_word_i   (data_word_i),
    .valid_bytes_i (valid_bytes_i),
    .last_word_i   (last_word_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .hash_value_o  (hash_value_o)
  );

`ifndef SYNTHESIS
  // a finished hash never overwrites one that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten before it was taken");

  // the block is busy in the cycle after taking an item
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready stayed high after an item was accepted");

  // the multiplier is never started and no write-back is made while the block waits for an item
  a_no_mul_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!cmd.mul_issue && (cmd.wb_sel == WB_NONE)))
    else $error("datapath active while idle");
`endif

endmodule
